>>> design/ufs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ufs_pkg
// Shared types and constants for the UTF-8 sanitize filter: byte classes,
// the run word passed from the classifier to the serializer, queue sizing.
// ----------------------------------------------------------------------------
package ufs_pkg;

    localparam int RunQDepth = 4;
    localparam int RunQPtrW  = $clog2(RunQDepth);
    localparam int RunQCntW  = $clog2(RunQDepth + 1);

    localparam logic [7:0] AsciiLimit  = 8'h80;
    localparam logic [7:0] PrintMin    = 8'd32;
    localparam logic [7:0] CharTab     = 8'h09;
    localparam logic [7:0] CharNewline = 8'h0A;

    localparam logic [7:0] Lead2Mask = 8'hE0;
    localparam logic [7:0] Lead2Code = 8'hC0;
    localparam logic [7:0] Lead3Mask = 8'hF0;
    localparam logic [7:0] Lead3Code = 8'hE0;
    localparam logic [7:0] Lead4Mask = 8'hF8;
    localparam logic [7:0] Lead4Code = 8'hF0;
    localparam logic [7:0] ContMask  = 8'hC0;
    localparam logic [7:0] ContCode  = 8'h80;

    localparam logic [2:0] SeqNone = 3'd0;
    localparam logic [2:0] SeqLen2 = 3'd2;
    localparam logic [2:0] SeqLen3 = 3'd3;
    localparam logic [2:0] SeqLen4 = 3'd4;

    // One run: all results caused by a single input word.
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [1:0]      last_idx;
        logic            present;
        logic            str_end;
    } run_t;

endpackage

>>> design/ufs_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ufs_front
// Input side: accepts words, tracks the open UTF-8 sequence and builds one
// run per word that produces any result or ends a string.
// ----------------------------------------------------------------------------
module ufs_front
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [7:0]      in_byte,
    input  logic            string_last,
    input  logic            q_full,
    output logic            push,
    output ufs_pkg::run_t   push_run
);
    import ufs_pkg::*;

    logic [7:0] held_bytes_reg [3];
    logic [1:0] held_count_reg;
    logic [1:0] held_count_next;
    logic [2:0] seq_len_reg;
    logic [2:0] seq_len_next;

    logic       accept;
    logic       is_cont;
    logic       seq_open;
    logic       completes;
    logic       store_cont;
    logic       store_lead;
    logic       fresh_pass;
    logic [2:0] fresh_len;
    run_t       run;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    assign is_cont    = (in_byte & ContMask) == ContCode;
    assign seq_open   = seq_len_reg != SeqNone;
    assign completes  = seq_open && is_cont && (({1'b0, held_count_reg} + 3'd1) >= seq_len_reg);
    assign store_cont = seq_open && is_cont && !completes;

    always_comb
    begin
        fresh_pass = 1'b0;
        fresh_len  = SeqNone;
        if (in_byte < AsciiLimit)
        begin
            fresh_pass = (in_byte >= PrintMin) || (in_byte == CharTab) ||
                         (in_byte == CharNewline);
        end
        else if ((in_byte & Lead2Mask) == Lead2Code)
        begin
            fresh_len = SeqLen2;
        end
        else if ((in_byte & Lead3Mask) == Lead3Code)
        begin
            fresh_len = SeqLen3;
        end
        else if ((in_byte & Lead4Mask) == Lead4Code)
        begin
            fresh_len = SeqLen4;
        end
    end

    // A byte that is not taken by an open sequence is judged afresh.
    assign store_lead = !(seq_open && is_cont) && (fresh_len != SeqNone);

    always_comb
    begin
        run.bytes    = {4{in_byte}};
        run.last_idx = 2'd0;
        run.present  = 1'b0;
        run.str_end  = string_last;
        if (completes)
        begin
            run.bytes[0] = held_bytes_reg[0];
            if (held_count_reg > 2'd1)
            begin
                run.bytes[1] = held_bytes_reg[1];
            end
            if (held_count_reg > 2'd2)
            begin
                run.bytes[2] = held_bytes_reg[2];
            end
            run.last_idx = held_count_reg;
            run.present  = 1'b1;
        end
        else if (!(seq_open && is_cont) && fresh_pass)
        begin
            run.present = 1'b1;
        end
        if (!run.present)
        begin
            run.bytes = '0;
        end
    end

    assign push     = accept && (run.present || string_last);
    assign push_run = run;

    always_comb
    begin
        held_count_next = held_count_reg;
        seq_len_next    = seq_len_reg;
        if (store_cont)
        begin
            held_count_next = held_count_reg + 2'd1;
        end
        else if (store_lead)
        begin
            held_count_next = 2'd1;
            seq_len_next    = fresh_len;
        end
        else
        begin
            held_count_next = 2'd0;
            seq_len_next    = SeqNone;
        end
        if (string_last)
        begin
            held_count_next = 2'd0;
            seq_len_next    = SeqNone;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_count_reg <= 2'd0;
            seq_len_reg    <= SeqNone;
        end
        else if (accept)
        begin
            held_count_reg <= held_count_next;
            seq_len_reg    <= seq_len_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && store_cont)
        begin
            held_bytes_reg[held_count_reg] <= in_byte;
        end
        else if (accept && store_lead)
        begin
            held_bytes_reg[0] <= in_byte;
        end
    end

endmodule

>>> design/ufs_run_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ufs_run_queue
// Short queue of runs between the classifier and the serializer.
// ----------------------------------------------------------------------------
module ufs_run_queue
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  ufs_pkg::run_t   push_run,
    input  logic            pop,
    output logic            full,
    output logic            not_empty,
    output ufs_pkg::run_t   head_run
);
    import ufs_pkg::*;

    run_t                entries_reg [RunQDepth];
    logic [RunQPtrW-1:0] wr_ptr_reg;
    logic [RunQPtrW-1:0] rd_ptr_reg;
    logic [RunQCntW-1:0] count_reg;
    logic [RunQCntW-1:0] count_next;

    assign full      = count_reg == RunQCntW'(RunQDepth);
    assign not_empty = count_reg != '0;
    assign head_run  = entries_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_run;
        end
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= RunQCntW'(RunQDepth))
        else $error("run queue count beyond depth");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!full || pop))
        else $error("run pushed into a full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("run popped from an empty queue");

    a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("empty queue with pointers apart");
`endif

endmodule

>>> design/ufs_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ufs_back
// Output side: walks the head run one byte per cycle, while out_ready allows,
// into the output register and pops the run as its last byte is loaded.
// ----------------------------------------------------------------------------
module ufs_back
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_not_empty,
    input  ufs_pkg::run_t   head_run,
    output logic            pop,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [7:0]      out_byte,
    output logic            byte_present,
    output logic            run_last,
    output logic            string_end
);
    import ufs_pkg::*;

    logic [1:0] idx_reg;
    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic       present_reg;
    logic       run_last_reg;
    logic       str_end_reg;
    logic       load;
    logic       at_end;

    assign load   = q_not_empty && (!out_valid_reg || out_ready);
    assign at_end = idx_reg == head_run.last_idx;
    assign pop    = load && at_end;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                idx_reg       <= at_end ? 2'd0 : idx_reg + 2'd1;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_byte_reg <= head_run.bytes[idx_reg];
            present_reg  <= head_run.present;
            run_last_reg <= at_end;
            str_end_reg  <= at_end && head_run.str_end;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_byte     = out_byte_reg;
    assign byte_present = present_reg;
    assign run_last     = run_last_reg;
    assign string_end   = str_end_reg;

endmodule

>>> design/utf8_sanitize_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_sanitize_filter
// UTF-8 cleaning filter: drops bytes below 32 other than tab and newline, stray
// continuations, invalid leads and broken or unfinished sequences; emits complete sequences whole.
// ----------------------------------------------------------------------------
//  Channel | Handshake           | Payload
//  --------+---------------------+-------------------------------------------------
//  in      | in_valid/in_ready   | in_byte[7:0], string_last
//  out     | out_valid/out_ready | out_byte[7:0], byte_present, run_last, string_end
//
// One input word is accepted per cycle while the run queue has room; its results
// leave one per cycle while out_ready allows, so a completed 4-byte sequence
// is emitted as four output bytes. A result passes a run queue entry, then the
// output register. Reset clears the sequence tracker, the queue pointers and the
// output valid. Input stalls only when the four-entry run queue is full.
// ----------------------------------------------------------------------------
module utf8_sanitize_filter
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  in_byte,
    input  logic        string_last,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic        byte_present,
    output logic        run_last,
    output logic        string_end
);
    import ufs_pkg::*;

    logic q_full;
    logic q_not_empty;
    logic push;
    logic pop;
    run_t push_run;
    run_t head_run;

    ufs_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_byte     (in_byte),
        .string_last (string_last),
        .q_full      (q_full),
        .push        (push),
        .push_run    (push_run)
    );

    ufs_run_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_run  (push_run),
        .pop       (pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head_run  (head_run)
    );

    ufs_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_not_empty  (q_not_empty),
        .head_run     (head_run),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_byte     (out_byte),
        .byte_present (byte_present),
        .run_last     (run_last),
        .string_end   (string_end)
    );

endmodule
